// ===== rtl/cstp_pkg.sv =====
// Shared types, constants and saturation helpers for the cascaded speed/tilt controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package cstp_pkg;

  // Fixed-point format of angles, speeds and gains
  localparam int FRAC_BITS = 8;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int MS_PER_S  = 1000;
  localparam int C03       = (3 * ONE_Q + 5) / 10;   // 0.3 in Q format
  localparam int C19       = (19 * ONE_Q + 5) / 10;  // 1.9 in Q format
  localparam int TI_LIM    = 700 * ONE_Q;            // tilt integral clamp
  localparam int ERR_THR   = 15 * ONE_Q;             // boost threshold on tilt error
  localparam int DIVK      = MS_PER_S * ONE_Q;       // ms and Q scaling of integrals
  localparam int DEN_W     = ($clog2(DIVK + 1) > 16) ? $clog2(DIVK + 1) : 16;
  localparam int NUM_W     = 64;
  localparam int CNT_W     = $clog2(NUM_W);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TILT_KP  = 3'd0,
    REG_TILT_KI  = 3'd1,
    REG_TILT_KD  = 3'd2,
    REG_SPEED_KP = 3'd3,
    REG_SPEED_KI = 3'd4,
    REG_FILT     = 3'd5
  } reg_idx_t;

  localparam logic [8:0] FILT_RESET = 9'd102;
  localparam logic [8:0] FILT_ONE   = 9'd256;

  typedef struct packed {
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic signed [15:0] kpv;
    logic signed [15:0] kiv;
    logic        [8:0]  coef;
  } cfg_t;

  // One classified request on its way from front to back
  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [16:0] verr;
    logic        [15:0] ms;
  } item_t;

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF_FFFF)       sat48 = 48'sh7FFF_FFFF_FFFF;
    else if (v < -66'sh0_8000_0000_0000) sat48 = 48'sh8000_0000_0000;
    else                                 sat48 = v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF)       sat32 = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) sat32 = 32'sh8000_0000;
    else                            sat32 = v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [65:0] v);
    if (v > 66'sh7F_FFFF)       sat24 = 24'sh7F_FFFF;
    else if (v < -66'sh80_0000) sat24 = 24'sh80_0000;
    else                        sat24 = v[23:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cstp_front.sv =====
// Front end: takes input requests, unpacks them, fixes zero elapsed time, forms speed error.
// Depends on cstp_pkg; feeds cstp_fifo.
`default_nettype none

module cstp_front
  import cstp_pkg::*;
(
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic        full_i,
  output logic             push_o,
  output item_t            item_o
);

  logic signed [15:0] spd;
  logic signed [15:0] tgt;
  logic        [15:0] ms_raw;

  // Unpack the request
  assign spd    = in_tdata[31:16];
  assign tgt    = in_tdata[47:32];
  assign ms_raw = in_tdata[63:48];

  // Take a request whenever the queue has room
  assign in_tready = !full_i;
  assign push_o    = in_tvalid && !full_i;

  always_comb begin
    item_o.angle = in_tdata[15:0];
    item_o.verr  = 17'(tgt) - 17'(spd);
    item_o.ms    = (ms_raw == 16'd0) ? 16'd1 : ms_raw;  // zero elapsed time counts as 1 ms
  end

endmodule

`default_nettype wire

// ===== rtl/cstp_fifo.sv =====
// Two-entry queue of classified requests between front and back.
// Depends on cstp_pkg for the item type.
`default_nettype none

module cstp_fifo
  import cstp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_i,
  input  item_t      item_i,
  input  wire logic  pop_i,
  output item_t      item_o,
  output logic       full_o,
  output logic       empty_o
);

  item_t       mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign full_o  = (count_r == 2'd2);
  assign empty_o = (count_r == 2'd0);
  assign item_o  = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_r <= !wr_ptr_r;
      if (pop_i)  rd_ptr_r <= !rd_ptr_r;
      if (push_i && !pop_i)      count_r <= count_r + 2'd1;
      else if (pop_i && !push_i) count_r <= count_r - 2'd1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= item_i;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push_i |-> !full_o)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop_i |-> !empty_o)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/cstp_div.sv =====
// Floor dividers: a serial divider for the elapsed-time division and a constant divider
// for the two integral scalings by 1000 * 2^FRAC_BITS. Depends on cstp_pkg.
`default_nettype none

module cstp_div
  import cstp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic        [DEN_W-1:0] den_i,
  output logic                         done_o,
  output logic signed [NUM_W-1:0]      quot_o
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIX  = 3'b100
  } dstate_t;

  dstate_t            state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [NUM_W-1:0]   q_r;
  logic [DEN_W:0]     rem_r;
  logic [DEN_W-1:0]   den_r;
  logic               neg_r;
  logic [DEN_W:0]     rem_sh;
  logic               fit;

  // One restoring step
  assign rem_sh = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
  assign fit    = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start_i) begin
            state_r <= D_RUN;
            cnt_r   <= '0;
            rem_r   <= '0;
            den_r   <= den_i;
            neg_r   <= num_i[NUM_W-1];
            q_r     <= num_i[NUM_W-1] ? NUM_W'(-num_i) : num_i;
          end
        end
        D_RUN: begin
          rem_r <= fit ? (rem_sh - {1'b0, den_r}) : rem_sh;
          q_r   <= {q_r[NUM_W-2:0], fit};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NUM_W - 1)) state_r <= D_FIX;
        end
        D_FIX: begin
          // Round toward minus infinity for negative numerators
          quot_o  <= neg_r ? (-$signed(q_r) - NUM_W'(rem_r != '0)) : $signed(q_r);
          done_o  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> state_r == D_IDLE)
    else $error("divider started while busy");
`endif

endmodule

// Floor division by DIVK = 125 * 2^(FRAC_BITS+3): the power of two is a shift, the odd
// part is taken a byte per cycle with a small reciprocal multiply.
module cstp_kdiv
  import cstp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  output logic                         done_o,
  output logic signed [NUM_W-1:0]      quot_o
);

  localparam int K_SH  = FRAC_BITS + 3;                       // power-of-two part
  localparam int K_ODD = DIVK >> K_SH;                        // odd part, 125
  localparam int R_SH  = 22;
  localparam int K_RCP = ((1 << R_SH) + K_ODD - 1) / K_ODD;   // exact for digits < 32000
  localparam int ND    = (NUM_W - K_SH + 7) / 8;              // quotient bytes
  localparam int PW    = ND * 8;

  typedef enum logic [2:0] {
    K_IDLE = 3'b001,
    K_RUN  = 3'b010,
    K_FIX  = 3'b100
  } kstate_t;

  kstate_t          state_r;
  logic [3:0]       cnt_r;
  logic [PW-1:0]    sh_r;
  logic [PW-1:0]    q_r;
  logic [6:0]       rem_r;
  logic             lo_nz_r;
  logic             neg_r;
  logic [NUM_W-1:0] mag;
  logic [14:0]      dig_v;
  logic [30:0]      dig_p;
  logic [7:0]       dig_q;
  logic [6:0]       dig_r;
  logic             rem_nz;

  // Magnitude, then one quotient byte per cycle
  assign mag    = num_i[NUM_W-1] ? NUM_W'(-num_i) : num_i;
  assign dig_v  = {rem_r, sh_r[PW-1 -: 8]};
  assign dig_p  = 31'(dig_v) * 31'(K_RCP);
  assign dig_q  = dig_p[R_SH +: 8];
  assign dig_r  = 7'(dig_v - 15'(dig_q) * 15'(K_ODD));
  assign rem_nz = (rem_r != '0) || lo_nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= K_IDLE;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_r)
        K_IDLE: begin
          if (start_i) begin
            state_r <= K_RUN;
            cnt_r   <= '0;
            rem_r   <= '0;
            q_r     <= '0;
            sh_r    <= PW'(mag[NUM_W-1:K_SH]);
            lo_nz_r <= (mag[K_SH-1:0] != '0);
            neg_r   <= num_i[NUM_W-1];
          end
        end
        K_RUN: begin
          rem_r <= dig_r;
          q_r   <= {q_r[PW-9:0], dig_q};
          sh_r  <= {sh_r[PW-9:0], 8'd0};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(ND - 1)) state_r <= K_FIX;
        end
        K_FIX: begin
          // Round toward minus infinity for negative numerators
          quot_o  <= neg_r ? (-$signed(NUM_W'(q_r)) - NUM_W'(rem_nz)) : $signed(NUM_W'(q_r));
          done_o  <= 1'b1;
          state_r <= K_IDLE;
        end
        default: state_r <= K_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_kstart_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> state_r == K_IDLE)
    else $error("constant divider started while busy");
  a_krem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == K_RUN |-> rem_r < 7'(K_ODD))
    else $error("constant divider remainder out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/cstp_back.sv =====
// Back end: sequencer running the outer PI and inner PID on one request at a time.
// Depends on cstp_pkg and cstp_div; drives the result register.
`default_nettype none

module cstp_back
  import cstp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cfg_t             cfg_i,
  input  wire logic        empty_i,
  input  item_t            item_i,
  output logic             pop_o,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_drive
);

  typedef enum logic [20:0] {
    S_IDLE  = 21'd1,
    S_M1    = 21'd1 << 1,
    S_SEI   = 21'd1 << 2,
    S_KPV   = 21'd1 << 3,
    S_KLO   = 21'd1 << 4,
    S_KHI   = 21'd1 << 5,
    S_KSUM  = 21'd1 << 6,
    S_KWAIT = 21'd1 << 7,
    S_REF   = 21'd1 << 8,
    S_ERR   = 21'd1 << 9,
    S_F1    = 21'd1 << 10,
    S_F2    = 21'd1 << 11,
    S_D1    = 21'd1 << 12,
    S_DWAIT = 21'd1 << 13,
    S_I1    = 21'd1 << 14,
    S_I2    = 21'd1 << 15,
    S_IWAIT = 21'd1 << 16,
    S_P1    = 21'd1 << 17,
    S_P2    = 21'd1 << 18,
    S_KD    = 21'd1 << 19,
    S_OUT   = 21'd1 << 20
  } state_t;

  state_t state_r, state_nxt;

  // Loop state
  logic signed [47:0] sei_r;
  logic signed [31:0] ti_r;
  logic signed [15:0] fa_r;

  // Working registers
  logic signed [15:0] angle_r;
  logic signed [16:0] verr_r;
  logic        [15:0] ms_r;
  logic signed [33:0] vm_r;
  logic signed [32:0] kpvp_r;
  logic signed [40:0] lo_r;
  logic signed [39:0] hi_r;
  logic signed [63:0] dq_r;
  logic signed [31:0] ref_r;
  logic signed [31:0] err_r;
  logic signed [25:0] fm_r;
  logic signed [15:0] filt_r;
  logic signed [26:0] derr_r;
  logic signed [32:0] kim_r;
  logic signed [55:0] p_r;
  logic signed [42:0] kdt_r;
  logic               start_r;
  logic               kstart_r;
  logic signed [NUM_W-1:0] dnum_r;
  logic        [DEN_W-1:0] dden_r;
  logic               div_done;
  logic signed [NUM_W-1:0] div_q;
  logic               kdiv_done;
  logic signed [NUM_W-1:0] kdiv_q;

  logic        [8:0]  a;
  logic signed [47:0] pm;
  logic signed [26:0] fsum;
  logic signed [16:0] fdiff;
  logic signed [65:0] ref_sum;
  logic signed [65:0] ti_sum;
  logic signed [65:0] u_sum;
  logic signed [31:0] ti_new;

  localparam logic signed [FRAC_BITS+3:0] C19_S = (FRAC_BITS + 4)'(C19);

  // Division by elapsed time
  cstp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start_r),
    .num_i   (dnum_r),
    .den_i   (dden_r),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // Integral scaling by 1000 * 2^FRAC_BITS
  cstp_kdiv u_kdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (kstart_r),
    .num_i   (dnum_r),
    .done_o  (kdiv_done),
    .quot_o  (kdiv_q)
  );

  // Filter weight above one acts as one
  assign a = (cfg_i.coef > FILT_ONE) ? FILT_ONE : cfg_i.coef;

  // Datapath terms
  assign pm      = cfg_i.kp * err_r;
  assign fsum    = fm_r + $signed({1'b0, FILT_ONE - a}) * fa_r;
  assign fdiff   = 17'(filt_r) - 17'(fa_r);
  assign ref_sum = 66'(kpvp_r >>> FRAC_BITS) + 66'(dq_r) - 66'(C03);
  assign ti_sum  = 66'(ti_r) + 66'(kdiv_q);
  assign u_sum   = 66'(p_r) + 66'(ti_r) + 66'(kdt_r >>> FRAC_BITS);

  // Tilt integral clamp
  always_comb begin
    if (ti_sum > 66'(TI_LIM))       ti_new = 32'(TI_LIM);
    else if (ti_sum < -66'(TI_LIM)) ti_new = -32'(TI_LIM);
    else                            ti_new = ti_sum[31:0];
  end

  assign pop_o = (state_r == S_IDLE) && !empty_i;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!empty_i) state_nxt = S_M1;
      S_M1:    state_nxt = S_SEI;
      S_SEI:   state_nxt = S_KPV;
      S_KPV:   state_nxt = S_KLO;
      S_KLO:   state_nxt = S_KHI;
      S_KHI:   state_nxt = S_KSUM;
      S_KSUM:  state_nxt = S_KWAIT;
      S_KWAIT: if (kdiv_done) state_nxt = S_REF;
      S_REF:   state_nxt = S_ERR;
      S_ERR:   state_nxt = S_F1;
      S_F1:    state_nxt = S_F2;
      S_F2:    state_nxt = S_D1;
      S_D1:    state_nxt = S_DWAIT;
      S_DWAIT: if (div_done) state_nxt = S_I1;
      S_I1:    state_nxt = S_I2;
      S_I2:    state_nxt = S_IWAIT;
      S_IWAIT: if (kdiv_done) state_nxt = S_P1;
      S_P1:    state_nxt = S_P2;
      S_P2:    state_nxt = S_KD;
      S_KD:    state_nxt = S_OUT;
      S_OUT:   if (!out_tvalid || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      start_r    <= 1'b0;
      kstart_r   <= 1'b0;
      out_tvalid <= 1'b0;
      sei_r      <= '0;
      ti_r       <= '0;
      fa_r       <= '0;
    end else begin
      state_r  <= state_nxt;
      start_r  <= (state_r == S_D1);
      kstart_r <= (state_r == S_KSUM) || (state_r == S_I2);
      // Result register handshake
      if ((state_r == S_OUT) && (!out_tvalid || out_tready)) out_tvalid <= 1'b1;
      else if (out_tready)                                    out_tvalid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!empty_i) begin
            angle_r <= item_i.angle;
            verr_r  <= item_i.verr;
            ms_r    <= item_i.ms;
          end
        end
        // Outer PI
        S_M1:    vm_r   <= verr_r * $signed({1'b0, ms_r});
        S_SEI:   sei_r  <= sat48(66'(sei_r) + 66'(vm_r));
        S_KPV:   kpvp_r <= cfg_i.kpv * verr_r;
        S_KLO:   lo_r   <= cfg_i.kiv * $signed({1'b0, sei_r[23:0]});
        S_KHI:   hi_r   <= cfg_i.kiv * $signed(sei_r[47:24]);
        S_KSUM:  dnum_r <= (64'(hi_r) <<< 24) + 64'(lo_r);
        S_KWAIT: if (kdiv_done) dq_r <= kdiv_q;
        S_REF:   ref_r <= sat32(ref_sum);
        S_ERR:   err_r <= sat32(66'(ref_r) - 66'(angle_r));
        // Angle low-pass and derivative
        S_F1:    fm_r   <= $signed({1'b0, a}) * angle_r;
        S_F2:    filt_r <= 16'(fsum >>> 8);
        S_D1: begin
          dnum_r <= 64'(fdiff) * 64'(MS_PER_S);
          dden_r <= DEN_W'(ms_r);
        end
        S_DWAIT: if (div_done) derr_r <= 27'(div_q);
        // Inner integral
        S_I1:    kim_r  <= cfg_i.ki * $signed({1'b0, ms_r});
        S_I2:    dnum_r <= 64'(kim_r) * 64'(err_r);
        S_IWAIT: if (kdiv_done) ti_r <= ti_new;
        // Proportional with boost, derivative term
        S_P1:    p_r <= 56'(pm >>> FRAC_BITS);
        S_P2:    if (err_r > 32'(ERR_THR)) p_r <= 56'((p_r * C19_S) >>> FRAC_BITS);
        S_KD:    kdt_r <= cfg_i.kd * derr_r;
        S_OUT: begin
          if (!out_tvalid || out_tready) begin
            out_drive <= sat24(u_sum);
            fa_r      <= filt_r;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_ti_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ti_r <= 32'(TI_LIM)) && (ti_r >= -32'(TI_LIM)))
    else $error("tilt integral outside clamp");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |=> state_r == S_M1)
    else $error("request popped but sequence not started");
`endif

endmodule

`default_nettype wire

// ===== rtl/cascaded_speed_tilt_pid.sv =====
// Each accepted request runs through the back-end sequence, which holds the serial division
// by elapsed time and the two byte-wise integral scalings. The back end takes a new request
// only once the result of the last one is registered; a held-off result stalls the back end
// at its last step. Two further requests queue while one is worked on.
// Reset: synchronous, active low; clears loop state, queue and handshakes, gains to zero,
// filter weight to 102. Top level: config registers, front, queue and back end.
`default_nettype none

module cascaded_speed_tilt_pid
  import cstp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // tilt_angle, speed, speed_target, elapsed_ms
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // drive
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t  cfg_r;
  item_t f_item;
  item_t q_item;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp   <= '0;
      cfg_r.ki   <= '0;
      cfg_r.kd   <= '0;
      cfg_r.kpv  <= '0;
      cfg_r.kiv  <= '0;
      cfg_r.coef <= FILT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TILT_KP:  cfg_r.kp   <= cfg_data;
        REG_TILT_KI:  cfg_r.ki   <= cfg_data;
        REG_TILT_KD:  cfg_r.kd   <= cfg_data;
        REG_SPEED_KP: cfg_r.kpv  <= cfg_data;
        REG_SPEED_KI: cfg_r.kiv  <= cfg_data;
        REG_FILT:     cfg_r.coef <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  cstp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .full_i    (full),
    .push_o    (push),
    .item_o    (f_item)
  );

  cstp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .full_o  (full),
    .empty_o (empty)
  );

  cstp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .empty_i    (empty),
    .item_i     (q_item),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_drive  (out_tdata)
  );

endmodule

`default_nettype wire
